@@ rtl/buddy_block_allocator_defines.svh @@
// Assertion helpers for the buddy allocator checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

	localparam int ADDR_W    = 48;
	localparam int ORDER_W   = 6;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [ORDER_W-1:0]   order_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_NO_BLOCK    = 2'd1;
	localparam status_t ST_BAD_REQ     = 2'd2;
	localparam status_t ST_DOUBLE_FREE = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam cfg_idx_t CFG_POOL_BASE = 2'd0;
	localparam cfg_idx_t CFG_BLK_LOG2  = 2'd1;
	localparam cfg_idx_t CFG_POOL_LOG2 = 2'd2;
	localparam cfg_idx_t CFG_MAX_ORDER = 2'd3;

	localparam order_t RST_BLK_LOG2   = 6'd12;
	localparam order_t RST_POOL_LOG2  = 6'd22;
	localparam order_t RST_MAX_ORDER  = 6'd22;

	localparam logic [63:0] LIMIT_4G = 64'h0000_0001_0000_0000;

endpackage

`default_nettype wire

@@ rtl/buddy_block_allocator.sv @@
`default_nettype none

// Buddy allocator over one pool of 2^(pool order) bytes at the pool base, split
// into minimum blocks of 2^(minimum order) bytes, at most 2^LOG_BLOCKS of them.
// Each input transfer is one allocate or free request and yields exactly one
// result transfer (status, block_address). All per-block state (free tag,
// order, list links) sits in four single-port-read synchronous memories of
// 2^LOG_BLOCKS entries; the per-order list heads are registers. Requests are
// handled one at a time by a sequencer that issues one memory read per step
// and writes back.
// After reset, and after every configuration transfer, a clearing pass over all
// 2^LOG_BLOCKS entries runs before the first request is taken (configuration
// transfers are still taken during it and restart it). While cfg_valid is high
// in_ready stays low, so a configuration transfer always wins over a request.
// An allocate walks the free lists from the requested order upward, skipping
// entries that fail the below-4GB filter, then unlinks the block and splits it;
// a free checks the request and the block's tag, then merges with free buddies
// upward. Both run long through the one memory read port: every list step and
// buddy check waits for its read. Rejected requests and a free of an already
// free block finish early. The sequencer passes through idle between requests.
// A result that is not taken holds the sequencer in its last step, but the
// next request is taken while an earlier result still waits.
module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int LOG_BLOCKS = 10
) (
	input  wire       clk,
	input  wire       arst_n,

	input  wire       in_valid,
	output logic      in_ready,
	input  wire       command,
	input  wire order_t   req_order,
	input  wire addr_t    address,
	input  wire       below_4gb,

	output logic      out_valid,
	input  wire       out_ready,
	output status_t   status,
	output addr_t     block_address,

	input  wire       cfg_valid,
	output logic      cfg_ready,
	input  wire cfg_idx_t cfg_index,
	input  wire addr_t    cfg_data
);

	localparam int BLOCKS = 1 << LOG_BLOCKS;
	localparam int LISTS  = LOG_BLOCKS + 1;
	localparam int IW     = LOG_BLOCKS;          // block index
	localparam int LW     = LOG_BLOCKS + 1;      // link, holds null
	localparam int RW     = $clog2(LISTS);       // list rank
	localparam logic [LW-1:0] NIL = LW'(BLOCKS);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_A_CHK, S_A_LIST, S_A_WALK, S_A_TEST, S_A_NEXT, S_A_SPLIT,
		S_F_CHK1, S_F_CHK2, S_F_RD, S_F_TAG,
		S_M_TEST, S_M_CHK, S_M_UPD,
		S_U_RD, S_U_FIX, S_U_CLR,
		S_P_A, S_P_B,
		S_DONE
	} state_t;

	// per-block state memories
	logic          tag_mem [BLOCKS];
	order_t        ord_mem [BLOCKS];
	logic [LW-1:0] nxt_mem [BLOCKS];
	logic [LW-1:0] prv_mem [BLOCKS];

	logic          tag_rd_q;
	order_t        ord_rd_q;
	logic [LW-1:0] nxt_rd_q;
	logic [LW-1:0] prv_rd_q;

	logic [IW-1:0] rd_addr;
	logic          tag_we, ord_we, nxt_we, prv_we;
	logic [IW-1:0] tag_wa, ord_wa, nxt_wa, prv_wa;
	logic          tag_wd;
	order_t        ord_wd;
	logic [LW-1:0] nxt_wd, prv_wd;

	// config registers
	addr_t  base_q;
	order_t min_q, pool_q, max_q;

	// sequencer
	state_t        state_q;
	logic [IW-1:0] clr_cnt_q;
	logic [LW-1:0] head_q [LISTS];

	logic          cmd_q;
	order_t        req_q;
	addr_t         addr_q;
	logic          low_q;

	order_t        ord_q;
	logic [RW-1:0] rank_q;
	logic [RW-1:0] lo_rank_q;
	logic [LW-1:0] id_q;
	logic [LW-1:0] steps_q;
	logic [63:0]   a_q;
	logic [63:0]   pow_q;
	logic [63:0]   rel_q;
	logic [63:0]   end_q;

	logic [IW-1:0] ul_id_q;
	logic [RW-1:0] ul_rank_q;
	state_t        ul_ret_q;

	logic [IW-1:0] pu_id_q;
	logic [RW-1:0] pu_rank_q;
	order_t        pu_order_q;
	state_t        pu_ret_q;
	logic [LW-1:0] pu_n_q;

	status_t       res_status_q;
	addr_t         res_addr_q;
	logic          out_valid_q;
	status_t       out_status_q;
	addr_t         out_addr_q;

	// derived values
	order_t        diff;
	logic          usable;
	logic [RW-1:0] top_rank;
	order_t        ord_c;
	logic [63:0]   base64;
	logic [63:0]   addr64;
	logic [63:0]   a_next;
	logic          fit;
	logic [IW-1:0] rank_bit;
	logic [IW-1:0] bid;
	logic [IW-1:0] id_merged;
	logic [RW-1:0] nr;
	logic [LW-1:0] half;
	logic          clr_last;
	logic          chk1_bad;
	logic          chk2_bad;
	logic [63:0]   id_full;
	logic          out_free;

	assign diff     = pool_q - min_q;
	assign usable   = (min_q <= pool_q) && (pool_q <= max_q) && (diff <= ORDER_W'(LOG_BLOCKS));
	assign top_rank = RW'(diff);
	assign ord_c    = (req_q < min_q) ? min_q : req_q;
	assign base64   = {16'd0, base_q};
	assign addr64   = {16'd0, addr_q};
	assign a_next   = base64 + ({{(64-IW){1'b0}}, id_q[IW-1:0]} << min_q);
	// whole block must end at or below 4 GiB, with 64-bit wrap of the sum
	assign fit      = !low_q || ((a_q + pow_q) <= LIMIT_4G);
	assign rank_bit = IW'(1) << rank_q;
	assign bid      = id_q[IW-1:0] ^ rank_bit;
	assign id_merged = id_q[IW-1:0] & ~rank_bit;
	assign nr       = rank_q - RW'(1);
	assign half     = {1'b0, id_q[IW-1:0]} + (LW'(1) << nr);
	assign clr_last = (clr_cnt_q == '0);

	assign chk1_bad = (req_q > max_q)
		|| ((addr64 & ((64'd1 << min_q) - 64'd1)) != 64'd0)
		|| !usable
		|| (addr64 < base64)
		|| (ord_c > pool_q);
	assign id_full  = rel_q >> min_q;
	assign chk2_bad = (addr64 >= end_q)
		|| ((rel_q & ((64'd1 << ord_q) - 64'd1)) != 64'd0)
		|| ((id_full >> IW) != 64'd0);

	// a pending configuration transfer takes the idle slot
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign block_address = out_addr_q;
	assign out_free  = !out_valid_q || out_ready;

	// memory port control
	always_comb begin
		rd_addr = '0;
		tag_we = 1'b0; tag_wa = clr_cnt_q; tag_wd = 1'b0;
		ord_we = 1'b0; ord_wa = clr_cnt_q; ord_wd = '0;
		nxt_we = 1'b0; nxt_wa = clr_cnt_q; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = clr_cnt_q; prv_wd = NIL;
		case (state_q)
			S_CLEAR: begin
				tag_we = 1'b1;
				ord_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
				// entry 0 carries the whole pool
				tag_wd = clr_last && usable;
				ord_wd = (clr_last && usable) ? pool_q : '0;
			end
			S_A_TEST: begin
				if (fit) begin
					tag_we = 1'b1;
					tag_wa = id_q[IW-1:0];
					tag_wd = 1'b0;
				end else begin
					rd_addr = id_q[IW-1:0];
				end
			end
			S_F_RD: rd_addr = id_q[IW-1:0];
			S_M_TEST: rd_addr = bid;
			S_M_UPD: begin
				ord_we = 1'b1;
				ord_wa = id_merged;
				ord_wd = min_q + ORDER_W'(rank_q) + ORDER_W'(1);
			end
			S_U_RD: rd_addr = ul_id_q;
			S_U_FIX: begin
				if (prv_rd_q < NIL) begin
					nxt_we = 1'b1;
					nxt_wa = prv_rd_q[IW-1:0];
					nxt_wd = nxt_rd_q;
				end
				if (nxt_rd_q < NIL) begin
					prv_we = 1'b1;
					prv_wa = nxt_rd_q[IW-1:0];
					prv_wd = prv_rd_q;
				end
			end
			S_U_CLR: begin
				nxt_we = 1'b1;
				nxt_wa = ul_id_q;
				nxt_wd = NIL;
				prv_we = 1'b1;
				prv_wa = ul_id_q;
				prv_wd = NIL;
			end
			S_P_A: begin
				tag_we = 1'b1;
				tag_wa = pu_id_q;
				tag_wd = 1'b1;
				ord_we = 1'b1;
				ord_wa = pu_id_q;
				ord_wd = pu_order_q;
				nxt_we = 1'b1;
				nxt_wa = pu_id_q;
				nxt_wd = head_q[pu_rank_q];
				prv_we = 1'b1;
				prv_wa = pu_id_q;
				prv_wd = NIL;
			end
			S_P_B: begin
				if (pu_n_q < NIL) begin
					prv_we = 1'b1;
					prv_wa = pu_n_q[IW-1:0];
					prv_wd = {1'b0, pu_id_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[tag_wa] <= tag_wd;
		tag_rd_q <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_wa] <= ord_wd;
		ord_rd_q <= ord_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd_q <= nxt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prv_we)
			prv_mem[prv_wa] <= prv_wd;
		prv_rd_q <= prv_mem[rd_addr];
	end

	// sequencer, list heads, config and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= IW'(BLOCKS - 1);
			for (int i = 0; i < LISTS; i++)
				head_q[i] <= NIL;
			base_q      <= '0;
			min_q       <= RST_BLK_LOG2;
			pool_q      <= RST_POOL_LOG2;
			max_q       <= RST_MAX_ORDER;
			out_valid_q <= 1'b0;
			ul_ret_q    <= S_IDLE;
			pu_ret_q    <= S_IDLE;
		end else begin
			// S_DONE refills the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				// any register write rebuilds the pool
				case (cfg_index)
					CFG_POOL_BASE: base_q <= cfg_data;
					CFG_BLK_LOG2:  min_q  <= cfg_data[ORDER_W-1:0];
					CFG_POOL_LOG2: pool_q <= cfg_data[ORDER_W-1:0];
					CFG_MAX_ORDER: max_q  <= cfg_data[ORDER_W-1:0];
					default: ;
				endcase
				for (int i = 0; i < LISTS; i++)
					head_q[i] <= NIL;
				clr_cnt_q <= IW'(BLOCKS - 1);
				state_q   <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (clr_last) begin
							if (usable)
								head_q[top_rank] <= '0;
							state_q <= S_IDLE;
						end else begin
							clr_cnt_q <= clr_cnt_q - IW'(1);
						end
					end
					S_IDLE: begin
						if (in_valid && in_ready) begin
							cmd_q      <= command;
							req_q      <= req_order;
							addr_q     <= address;
							low_q      <= below_4gb;
							res_addr_q <= '0;
							state_q    <= (command == CMD_FREE) ? S_F_CHK1 : S_A_CHK;
						end
					end

					// allocate
					S_A_CHK: begin
						rank_q    <= RW'(ord_c - min_q);
						lo_rank_q <= RW'(ord_c - min_q);
						pow_q     <= 64'd1 << ord_c;
						if (req_q > max_q) begin
							res_status_q <= ST_BAD_REQ;
							state_q      <= S_DONE;
						end else if (!usable || ord_c > pool_q) begin
							res_status_q <= ST_NO_BLOCK;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_A_LIST;
						end
					end
					S_A_LIST: begin
						id_q    <= head_q[rank_q];
						steps_q <= '0;
						state_q <= S_A_WALK;
					end
					S_A_WALK: begin
						// end of list, or walk cap hit on a damaged list
						if (id_q == NIL || steps_q == NIL) begin
							if (rank_q == top_rank) begin
								res_status_q <= ST_NO_BLOCK;
								state_q      <= S_DONE;
							end else begin
								rank_q  <= rank_q + RW'(1);
								state_q <= S_A_LIST;
							end
						end else begin
							a_q     <= a_next;
							state_q <= S_A_TEST;
						end
					end
					S_A_TEST: begin
						if (fit) begin
							res_addr_q <= a_q[ADDR_W-1:0];
							ul_id_q    <= id_q[IW-1:0];
							ul_rank_q  <= rank_q;
							ul_ret_q   <= S_A_SPLIT;
							state_q    <= S_U_RD;
						end else begin
							state_q <= S_A_NEXT;
						end
					end
					S_A_NEXT: begin
						id_q    <= nxt_rd_q;
						steps_q <= steps_q + LW'(1);
						state_q <= S_A_WALK;
					end
					S_A_SPLIT: begin
						if (rank_q > lo_rank_q) begin
							rank_q <= nr;
							// upper half goes onto the next lower list
							if (!half[LW-1]) begin
								pu_id_q    <= half[IW-1:0];
								pu_rank_q  <= nr;
								pu_order_q <= min_q + ORDER_W'(nr);
								pu_ret_q   <= S_A_SPLIT;
								state_q    <= S_P_A;
							end
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
					end

					// free
					S_F_CHK1: begin
						ord_q  <= ord_c;
						rank_q <= RW'(ord_c - min_q);
						rel_q  <= addr64 - base64;
						end_q  <= base64 + (64'd1 << pool_q);
						if (chk1_bad) begin
							res_status_q <= ST_BAD_REQ;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_F_CHK2;
						end
					end
					S_F_CHK2: begin
						id_q <= {1'b0, id_full[IW-1:0]};
						if (chk2_bad) begin
							res_status_q <= ST_BAD_REQ;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_F_RD;
						end
					end
					S_F_RD: state_q <= S_F_TAG;
					S_F_TAG: begin
						if (tag_rd_q) begin
							res_status_q <= ST_DOUBLE_FREE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_M_TEST;
						end
					end
					S_M_TEST: begin
						if (rank_q < top_rank) begin
							state_q <= S_M_CHK;
						end else begin
							res_status_q <= ST_OK;
							pu_id_q      <= id_q[IW-1:0];
							pu_rank_q    <= rank_q;
							pu_order_q   <= min_q + ORDER_W'(rank_q);
							pu_ret_q     <= S_DONE;
							state_q      <= S_P_A;
						end
					end
					S_M_CHK: begin
						if (tag_rd_q && ord_rd_q == min_q + ORDER_W'(rank_q)) begin
							ul_id_q   <= bid;
							ul_rank_q <= rank_q;
							ul_ret_q  <= S_M_UPD;
							state_q   <= S_U_RD;
						end else begin
							res_status_q <= ST_OK;
							pu_id_q      <= id_q[IW-1:0];
							pu_rank_q    <= rank_q;
							pu_order_q   <= min_q + ORDER_W'(rank_q);
							pu_ret_q     <= S_DONE;
							state_q      <= S_P_A;
						end
					end
					S_M_UPD: begin
						id_q    <= {1'b0, id_merged};
						rank_q  <= rank_q + RW'(1);
						state_q <= S_M_TEST;
					end

					// unlink from a list, at its head or in the middle
					S_U_RD: state_q <= S_U_FIX;
					S_U_FIX: begin
						if (!(prv_rd_q < NIL))
							head_q[ul_rank_q] <= nxt_rd_q;
						state_q <= S_U_CLR;
					end
					S_U_CLR: state_q <= ul_ret_q;

					// push at the list head
					S_P_A: begin
						pu_n_q              <= head_q[pu_rank_q];
						head_q[pu_rank_q]   <= {1'b0, pu_id_q};
						state_q             <= S_P_B;
					end
					S_P_B: state_q <= pu_ret_q;

					S_DONE: begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							out_status_q <= res_status_q;
							out_addr_q   <= (res_status_q == ST_OK && cmd_q == CMD_ALLOC)
								? res_addr_q : '0;
							state_q      <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/bba_checker.sv @@
`default_nettype none

`include "buddy_block_allocator_defines.svh"

module bba_checker
	import bba_pkg::*;
(
	input wire     clk,
	input wire     arst_n,
	input wire     in_valid,
	input wire     in_ready,
	input wire     out_valid,
	input wire     out_ready,
	input wire status_t status,
	input wire addr_t   block_address,
	input wire     cfg_valid,
	input wire     cfg_ready
);

	`BBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(block_address), "result changed while stalled")
	`BBA_ASSERT_IMPL(a_addr_zero, out_valid && status != ST_OK, block_address == '0, "address set on failed request")
	`BBA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")
	`BBA_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready, !in_ready, "request taken during pool rebuild")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
